// ===== rtl/core/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and decode functions for the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    // Sizes
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int TEXT_W              = 8;
    localparam int STATUS_W            = 3;
    localparam int DEPTH_W             = 7;
    localparam int OUT_TDATA_W         = 16;   // status + depth, padded to bytes
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    // Register map (register index = paddr >> 2)
    localparam logic REG_TERMINATOR = 1'b0;

    localparam logic [TEXT_W-1:0] TERMINATOR_RESET = 8'd35;   // '#'

    // Bracket characters
    localparam logic [TEXT_W-1:0] CHAR_OPEN_ROUND   = 8'd40;
    localparam logic [TEXT_W-1:0] CHAR_CLOSE_ROUND  = 8'd41;
    localparam logic [TEXT_W-1:0] CHAR_OPEN_SQUARE  = 8'd91;
    localparam logic [TEXT_W-1:0] CHAR_CLOSE_SQUARE = 8'd93;
    localparam logic [TEXT_W-1:0] CHAR_OPEN_CURLY   = 8'd123;
    localparam logic [TEXT_W-1:0] CHAR_CLOSE_CURLY  = 8'd125;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_END      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    function automatic kind_t open_kind(input logic [TEXT_W-1:0] b);
        kind_t k;
        unique case (b)
            CHAR_OPEN_ROUND:  k = KIND_ROUND;
            CHAR_OPEN_SQUARE: k = KIND_SQUARE;
            CHAR_OPEN_CURLY:  k = KIND_CURLY;
            default:          k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t close_kind(input logic [TEXT_W-1:0] b);
        kind_t k;
        unique case (b)
            CHAR_CLOSE_ROUND:  k = KIND_ROUND;
            CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
            CHAR_CLOSE_CURLY:  k = KIND_CURLY;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbc_out_buf.sv =====
// ----------------------------------------------------------------------------
// bbc_out_buf
// Two-entry output buffer (main + skid) with a registered upstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_out_buf
    import bbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [OUT_TDATA_W-1:0] in_data,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic [OUT_TDATA_W-1:0] out_data
);

    logic                   main_valid_reg, main_valid_next;
    logic [OUT_TDATA_W-1:0] main_data_reg,  main_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [OUT_TDATA_W-1:0] skid_data_reg,  skid_data_next;
    logic                   push;
    logic                   main_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                // no push possible while skid is full
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = in_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // skid only fills behind an occupied main entry
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with main entry empty");

    // a stalled main entry is never dropped
    a_main_held: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !out_ready) |=> (main_valid_reg && $stable(main_data_reg)))
        else $error("stalled output entry lost or changed");

    // an accepted item while main is stalled lands in skid
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("accepted item not captured in skid");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streaming bracket balance checker with a bracket-kind stack.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one text byte per transfer; m_* channel returns one
//   result per byte: status code and nesting depth after the byte.
//   Opening brackets ( [ { push their kind, closing brackets pop on a match.
//   A mismatch, close on empty stack or overflow raises a sticky error; later
//   bytes report "ignored" until the terminator byte, which reports the depth,
//   empties the stack and clears the error. Terminator value is set over APB
//   (register 0, byte address 0) and reads back there.
// Throughput:
//   A result is registered in the output buffer when its byte is accepted. One
//   byte per cycle sustained while s_tready is high; the top of stack is kept
//   in a register loaded on a push or from the stack memory's registered read
//   port, so push and pop both complete without stalling the byte stream.
// Reset:
//   Stack empty, error clear, terminator = '#', output buffer empty. Stack
//   memory contents are not cleared; only entries below the pointer are used.
// Stall:
//   A two-entry output buffer decouples the sides; s_tready drops only when
//   both entries hold results that the receiver has not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [TEXT_W-1:0]      s_tdata,    // [7:0] text_byte
    // result stream
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,    // [2:0] status, [9:3] nesting_depth,
                                                    // [15:10] zero
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output      logic [APB_DATA_W-1:0]  prdata,
    output      logic                   pready
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    // ---------------- configuration ----------------
    logic [TEXT_W-1:0] term_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TERMINATOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_reg <= TERMINATOR_RESET;
        else if (cfg_wr)
            term_reg <= pwdata[TEXT_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TERMINATOR)
            prdata = APB_DATA_W'(term_reg);
    end

    // ---------------- stack state ----------------
    kind_t          stack_mem [STACK_DEPTH];
    kind_t          top_reg;            // copy of stack_mem[sp_reg-1] when sp_reg != 0
    logic [SPW-1:0] sp_reg, sp_next;
    logic           err_reg, err_next;

    // ---------------- per-byte decision ----------------
    logic                   accept;
    logic                   is_term;
    kind_t                  ok_kind;
    kind_t                  ck_kind;
    status_t                status;
    logic [SPW-1:0]         depth_out;
    logic                   push_en;
    logic [AW-1:0]          wr_addr;
    logic [SPW-1:0]         rd_ptr;
    logic                   rd_en;
    logic                   res_ready;
    logic [OUT_TDATA_W-1:0] res_data;

    assign accept  = s_tvalid && s_tready;
    assign is_term = (s_tdata == term_reg);
    assign ok_kind = open_kind(s_tdata);
    assign ck_kind = close_kind(s_tdata);

    always_comb
    begin
        status    = ST_OK;
        sp_next   = sp_reg;
        err_next  = err_reg;
        push_en   = 1'b0;
        depth_out = sp_reg;
        if (accept)
        begin
            if (is_term)
            begin
                // terminator wins over bracket decoding
                status   = ST_END;
                sp_next  = '0;
                err_next = 1'b0;
            end
            else if (err_reg)
            begin
                status = ST_IGNORED;
            end
            else
            begin
                if (ok_kind != KIND_NONE)
                begin
                    if (sp_reg == SP_FULL)
                    begin
                        status   = ST_OVERFLOW;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
                else if (ck_kind != KIND_NONE)
                begin
                    if (sp_reg == '0)
                    begin
                        status   = ST_EMPTY;
                        err_next = 1'b1;
                    end
                    else if (top_reg != ck_kind)
                    begin
                        status   = ST_MISMATCH;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        sp_next = sp_reg - 1'b1;
                    end
                end
                depth_out = sp_next;
            end
        end
    end

    assign wr_addr  = sp_reg[AW-1:0];
    assign rd_ptr   = sp_next - 1'b1;
    assign rd_en    = (sp_next != '0);
    assign res_data = OUT_TDATA_W'({DEPTH_W'(depth_out), status});
    assign s_tready = res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
        end
    end

    // Stack memory: one write port, one registered read port feeding top_reg.
    // On a push the new top is taken straight from the byte.
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[wr_addr] <= ok_kind;
        if (push_en)
            top_reg <= ok_kind;
        else if (rd_en)
            top_reg <= stack_mem[rd_ptr[AW-1:0]];
    end

    // ---------------- result buffer ----------------
    bbc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_term) |=> (sp_reg == '0 && !err_reg))
        else $error("terminator did not clear stack and error");

    a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg && !is_term) |=> ($stable(sp_reg) && err_reg))
        else $error("stack changed while error held");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bracket_balance_checker. Text bytes go in over the
// s_* stream, and a local model of the bracket stack predicts status and depth
// for each accepted byte. Every m_* result is checked against the oldest
// prediction. Phases change the terminator over APB and switch the idle
// profiles. One phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import bbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = STACK_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest correct run
    localparam int DRAIN_CYCLES = 8;        // extra wait once every result is back
    localparam int HOLD_CYCLES  = 400;      // long result-side hold-off
    localparam int PHASE_BYTES  = 96;
    localparam int MAX_PRINTS   = 40;

    // Idle profiles used by the phases
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_profile_t;

    // One predicted result
    typedef struct packed {
        status_t              status;
        logic [DEPTH_W-1:0]   depth;
    } bracket_result_t;

    // ------------------------------------------------------------------------
    // DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TEXT_W-1:0]      s_tdata  = '0;      // [7:0] text_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [2:0] status, [9:3] nesting_depth, [15:10] zero
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    bracket_balance_checker #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [TEXT_W-1:0] text_bytes[$];           // bytes waiting for the driver
    bracket_result_t   awaited_results[$];      // predictions, oldest first

    // Predictor copy of the block state and its register
    kind_t             model_stack[DEPTH];
    int                model_sp    = 0;
    bit                model_err   = 1'b0;
    logic [TEXT_W-1:0] model_term  = TERMINATOR_RESET;

    // Text generator's own view of the nesting, only used to shape stimulus
    kind_t             text_stack[DEPTH];
    int                text_depth  = 0;

    int                sender_idle_pct    = 0;
    int                receiver_stall_pct = 0;
    int                hold_requests      = 0;
    int                holds_started      = 0;
    int                hold_left          = 0;

    int                error_count    = 0;
    int                cycle_count    = 0;
    int                bytes_queued   = 0;
    int                bytes_accepted = 0;
    int                results_seen   = 0;
    int                term_settings  = 1;
    int                status_count[6];

    bracket_result_t   want;
    logic [APB_DATA_W-1:0] read_value;

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is held low from the start and released on a falling
    // edge, so no process samples it changing at a rising edge.
    // ------------------------------------------------------------------------
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Run limit. Only a hang gets here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("bracket_balance_checker verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per failure, printing capped.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Predictor: applies one byte to the local stack model and returns the
    // status and depth the block should produce. The terminator test comes
    // first, so a terminator that is also a bracket ends the text.
    // ------------------------------------------------------------------------
    function automatic bracket_result_t predict_byte(input logic [TEXT_W-1:0] b);
        bracket_result_t r;
        bit              opening;
        bit              closing;
        kind_t           kind;
        opening = 1'b0;
        closing = 1'b0;
        kind    = KIND_NONE;
        case (b)
            CHAR_OPEN_ROUND:   begin opening = 1'b1; kind = KIND_ROUND;  end
            CHAR_OPEN_SQUARE:  begin opening = 1'b1; kind = KIND_SQUARE; end
            CHAR_OPEN_CURLY:   begin opening = 1'b1; kind = KIND_CURLY;  end
            CHAR_CLOSE_ROUND:  begin closing = 1'b1; kind = KIND_ROUND;  end
            CHAR_CLOSE_SQUARE: begin closing = 1'b1; kind = KIND_SQUARE; end
            CHAR_CLOSE_CURLY:  begin closing = 1'b1; kind = KIND_CURLY;  end
            default:           ;
        endcase
        r.status = ST_OK;
        if (b == model_term)
        begin
            // depth reported before the stack is emptied; error cleared too
            r.depth   = DEPTH_W'(model_sp);
            model_sp  = 0;
            model_err = 1'b0;
            r.status  = ST_END;
        end
        else if (model_err)
        begin
            r.depth  = DEPTH_W'(model_sp);
            r.status = ST_IGNORED;
        end
        else
        begin
            if (opening)
            begin
                if (model_sp >= DEPTH)
                begin
                    r.status  = ST_OVERFLOW;    // nothing pushed
                    model_err = 1'b1;
                end
                else
                begin
                    model_stack[model_sp] = kind;
                    model_sp++;
                end
            end
            else if (closing)
            begin
                if (model_sp == 0)
                begin
                    r.status  = ST_EMPTY;
                    model_err = 1'b1;
                end
                else if (model_stack[model_sp-1] != kind)
                begin
                    r.status  = ST_MISMATCH;    // no pop on a wrong kind
                    model_err = 1'b1;
                end
                else
                    model_sp--;
            end
            r.depth = DEPTH_W'(model_sp);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, holding each until its transfer completes.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (text_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_bytes.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The hold is
    // counted here, independent of the stimulus process.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left == 0 && hold_requests != holds_started)
        begin
            hold_left     <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
            m_tready      <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each input transfer, then checks each output
    // transfer against the oldest prediction. Predicting first keeps a
    // same-edge result in order with its byte.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(predict_byte(s_tdata));
                bytes_accepted <= bytes_accepted + 1;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result %h with no byte outstanding", m_tdata));
                else
                begin
                    want = awaited_results.pop_front();
                    status_count[want.status] <= status_count[want.status] + 1;
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_tdata[2:0], want.status.name()));
                    if (m_tdata[9:3] !== want.depth)
                        report_mismatch($sformatf("depth %0d, expected %0d (status %s)",
                                                  m_tdata[9:3], want.depth,
                                                  want.status.name()));
                    if (m_tdata[15:10] !== '0)
                        report_mismatch($sformatf("padding bits %b not zero", m_tdata[15:10]));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // APB access, driven on rising edges. The register changes at the access
    // edge, so the predictor's copy is updated right there.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only index 0 exists; other indexes are dropped
        if (addr[APB_ADDR_W-1:2] == REG_TERMINATOR)
            model_term = data[TEXT_W-1:0];
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_terminator_readback();
        apb_read(APB_ADDR_W'({REG_TERMINATOR, 2'b00}), read_value);
        if (read_value[TEXT_W-1:0] !== model_term)
            report_mismatch($sformatf("terminator reads %0d, expected %0d",
                                      read_value[TEXT_W-1:0], model_term));
    endtask

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [TEXT_W-1:0] c);
        text_bytes.push_back(c);
        bytes_queued++;
    endtask

    function automatic logic [TEXT_W-1:0] opener_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_OPEN_ROUND;
            KIND_SQUARE: return CHAR_OPEN_SQUARE;
            default:     return CHAR_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [TEXT_W-1:0] closer_char(input kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_CLOSE_ROUND;
            KIND_SQUARE: return CHAR_CLOSE_SQUARE;
            default:     return CHAR_CLOSE_CURLY;
        endcase
    endfunction

    // plain text: neither a bracket nor the current terminator
    function automatic logic [TEXT_W-1:0] random_filler();
        logic [TEXT_W-1:0] c;
        c = TEXT_W'($urandom_range(0, 255));
        while (c == model_term || c inside {CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND,
                                            CHAR_OPEN_SQUARE, CHAR_CLOSE_SQUARE,
                                            CHAR_OPEN_CURLY, CHAR_CLOSE_CURLY})
            c = TEXT_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic kind_t random_kind();
        return kind_t'($urandom_range(0, 2));
    endfunction

    // A bracket that collides with the terminator becomes filler instead.
    task automatic push_open(input kind_t k);
        logic [TEXT_W-1:0] c;
        c = opener_char(k);
        if (c == model_term)
            queue_byte(random_filler());
        else
        begin
            queue_byte(c);
            if (text_depth < DEPTH)
            begin
                text_stack[text_depth] = k;
                text_depth++;
            end
        end
    endtask

    // Always unwinds the generator's view so closing loops end.
    task automatic push_close(input kind_t k);
        logic [TEXT_W-1:0] c;
        c = closer_char(k);
        queue_byte(c == model_term ? random_filler() : c);
        if (text_depth > 0)
            text_depth--;
    endtask

    task automatic close_all();
        while (text_depth > 0)
            push_close(text_stack[text_depth-1]);
    endtask

    task automatic random_body(input int len);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 2))
                0:
                    if (text_depth < DEPTH)
                        push_open(random_kind());
                    else
                        queue_byte(random_filler());
                1:
                    if (text_depth > 0)
                        push_close(text_stack[text_depth-1]);
                    else
                        queue_byte(random_filler());
                default:
                    queue_byte(random_filler());
            endcase
        end
    endtask

    // One text, ended by the terminator. Mostly well nested with random
    // content; the rest carries a fault, fills the stack, or is raw noise.
    task automatic queue_text();
        int shape;
        shape      = $urandom_range(0, 99);
        text_depth = 0;
        if (shape < 60)
        begin
            random_body($urandom_range(1, 16));
            if ($urandom_range(0, 3) != 0)
                close_all();                    // else left open at the end
        end
        else if (shape < 80)
        begin
            random_body($urandom_range(0, 12));
            if (text_depth > 0 && $urandom_range(0, 1) == 0)
                push_close(kind_t'((text_stack[text_depth-1] + 1) % 3));  // wrong kind
            else
            begin
                close_all();
                push_close(random_kind());      // close on empty stack
            end
            repeat ($urandom_range(1, 4))
                queue_byte(TEXT_W'($urandom_range(0, 255)));
        end
        else if (shape < 85)
        begin
            repeat (DEPTH)
                push_open(random_kind());
            if ($urandom_range(0, 1) == 0)
            begin
                push_open(random_kind());       // one past a full stack
                repeat ($urandom_range(1, 3))
                    queue_byte(random_filler());
            end
            else
                close_all();
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                queue_byte(TEXT_W'($urandom_range(0, 255)));
        end
        queue_byte(model_term);
    endtask

    // ------------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------------
    task automatic set_idle(input idle_profile_t p);
        case (p)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
            default:       begin sender_idle_pct = 29; receiver_stall_pct = 29; end
        endcase
    endtask

    // Block is idle once every byte is sent and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_bytes.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [TEXT_W-1:0] term, input idle_profile_t p,
                             input bit long_hold);
        int start;
        wait_idle();
        apb_write(APB_ADDR_W'({REG_TERMINATOR, 2'b00}), APB_DATA_W'(term));
        check_terminator_readback();
        term_settings++;
        @(negedge clk);
        set_idle(p);
        start = bytes_queued;
        while (bytes_queued - start < PHASE_BYTES)
            queue_text();
        // with the whole phase queued, a hold makes the block back up
        if (long_hold)
            hold_requests++;
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        check_terminator_readback();            // reset value

        // Directed text under the reset terminator
        @(negedge clk);
        set_idle(IDLE_NONE);
        queue_byte(CHAR_OPEN_ROUND);            // nest all three kinds and unwind
        queue_byte(CHAR_OPEN_SQUARE);
        queue_byte(CHAR_OPEN_CURLY);
        queue_byte(CHAR_CLOSE_CURLY);
        queue_byte(CHAR_CLOSE_SQUARE);
        queue_byte(CHAR_CLOSE_ROUND);
        queue_byte(CHAR_CLOSE_ROUND);           // close on empty stack
        queue_byte(8'h61);                      // ignored while error held
        queue_byte(TERMINATOR_RESET);           // terminator clears the error
        queue_byte(CHAR_OPEN_CURLY);
        queue_byte(CHAR_OPEN_ROUND);
        queue_byte(CHAR_CLOSE_SQUARE);          // wrong kind, depth stays 2
        queue_byte(CHAR_CLOSE_ROUND);           // would match, but ignored
        queue_byte(TERMINATOR_RESET);           // reports depth 2, then clears
        queue_byte(8'h00);                      // field extremes as plain text
        queue_byte(8'hFF);
        queue_byte(8'h78);
        queue_byte(CHAR_OPEN_SQUARE);
        queue_byte(TERMINATOR_RESET);           // unclosed bracket at the end
        wait_idle();

        // Random phases across terminator values and idle profiles
        run_phase(8'h00, IDLE_SENDER, 1'b0);
        run_phase(8'hFF, IDLE_RECEIVER, 1'b0);
        run_phase(CHAR_OPEN_ROUND, IDLE_BOTH, 1'b0);    // terminator is a bracket

        // write to an unmapped index must leave the terminator alone
        apb_write(APB_ADDR_W'(3'b100), APB_DATA_W'(32'hFFFF_FF41));
        check_terminator_readback();

        run_phase(TERMINATOR_RESET, IDLE_NONE, 1'b1);   // long receiver hold
        run_phase(TEXT_W'($urandom_range(0, 255)), IDLE_BOTH, 1'b0);
        run_phase(CHAR_CLOSE_CURLY, IDLE_SENDER, 1'b0);
        run_phase(TERMINATOR_RESET, IDLE_RECEIVER, 1'b0);

        wait_idle();
        $display("covered %0d bytes, %0d results, %0d terminator settings, four idle profiles",
                 bytes_accepted, results_seen, term_settings);
        $display("statuses: ok %0d mismatch %0d empty %0d overflow %0d ignored %0d end %0d",
                 status_count[ST_OK], status_count[ST_MISMATCH], status_count[ST_EMPTY],
                 status_count[ST_OVERFLOW], status_count[ST_IGNORED], status_count[ST_END]);
        if (error_count == 0)
            $display("bracket_balance_checker verification clean");
        else
            $display("bracket_balance_checker verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 6; i++)
            status_count[i] = 0;
    end

endmodule

`default_nettype wire
